[rtl/ket_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the key edge tracker.
// No dependencies; every other file of the block imports this package.
package ket_pkg;

  localparam int CMD_W   = 3;
  localparam int KEY_W   = 10;
  localparam int CFG_W   = 9;
  localparam int REG_CNT = 8;
  localparam int REG_IW  = 3;
  localparam int DIR_W   = 2;
  localparam int STEP_W  = 3;

  localparam logic [CMD_W-1:0] CMD_KEY_DOWN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_KEY_UP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME_END = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KEY_QUERY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIR_QUERY = 3'd4;

  localparam logic [REG_IW-1:0] REG_UP_PRI    = 3'd0;
  localparam logic [REG_IW-1:0] REG_UP_ALT    = 3'd1;
  localparam logic [REG_IW-1:0] REG_DOWN_PRI  = 3'd2;
  localparam logic [REG_IW-1:0] REG_DOWN_ALT  = 3'd3;
  localparam logic [REG_IW-1:0] REG_LEFT_PRI  = 3'd4;
  localparam logic [REG_IW-1:0] REG_LEFT_ALT  = 3'd5;
  localparam logic [REG_IW-1:0] REG_RIGHT_PRI = 3'd6;
  localparam logic [REG_IW-1:0] REG_RIGHT_ALT = 3'd7;

  localparam logic [CFG_W-1:0] REG_RESET [REG_CNT] = '{
    9'd273, 9'd119, 9'd274, 9'd115, 9'd276, 9'd97, 9'd275, 9'd100
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY_EXEC,
    ST_QRY_REL,
    ST_DIR_ISSUE,
    ST_DIR_ACC,
    ST_DIR_CMP,
    ST_DONE
  } state_t;

  // Scan order: right, down, left, up; primary key before alternate.
  function automatic logic [REG_IW-1:0] dir_reg_index(input logic [STEP_W-1:0] step);
    logic [REG_IW-1:0] idx;
    begin
      case (step)
        3'd0:    idx = REG_RIGHT_PRI;
        3'd1:    idx = REG_RIGHT_ALT;
        3'd2:    idx = REG_DOWN_PRI;
        3'd3:    idx = REG_DOWN_ALT;
        3'd4:    idx = REG_LEFT_PRI;
        3'd5:    idx = REG_LEFT_ALT;
        3'd6:    idx = REG_UP_PRI;
        default: idx = REG_UP_ALT;
      endcase
      return idx;
    end
  endfunction

  // Direction code of a scan step: 3 right, 2 down, 1 left, 0 up.
  function automatic logic [DIR_W-1:0] dir_code_of(input logic [STEP_W-1:0] step);
    return ~step[STEP_W-1:1];
  endfunction

endpackage

[rtl/ket_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for items into and results out of the tracker.
// Depends on ket_pkg for field widths.
interface ket_in_if;
  import ket_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] keycode;

  modport source (output valid, output cmd, output keycode, input ready);
  modport sink   (input valid, input cmd, input keycode, output ready);
endinterface

interface ket_out_if;
  import ket_pkg::*;

  logic             valid;
  logic             ready;
  logic             key_is_held;
  logic             key_was_pressed;
  logic             key_was_released;
  logic             direction_valid;
  logic [DIR_W-1:0] direction_code;
  logic             range_error;

  modport source (output valid, output key_is_held, output key_was_pressed,
                  output key_was_released, output direction_valid,
                  output direction_code, output range_error, input ready);
  modport sink   (input valid, input key_is_held, input key_was_pressed,
                  input key_was_released, input direction_valid,
                  input direction_code, input range_error, output ready);
endinterface

[rtl/ket_mem.sv]
`timescale 1ns / 1ps
// Single-port key table: held bit, press stamp and release stamp per key.
// Registered read data; depends on ket_pkg only by convention.
module ket_mem #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 65,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic             wr_en,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  import ket_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/ket_cmp.sv]
`timescale 1ns / 1ps
// Shared stamp comparator: unsigned greater-than and equality.
// Used by the sequencer for key queries and direction scans.
module ket_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         gt,
  output logic         eq
);
  import ket_pkg::*;

  assign gt = a > b;
  assign eq = a == b;

endmodule

[rtl/key_edge_tracker_with_direction_core.sv]
`timescale 1ns / 1ps
// Top level of the key edge tracker: sequencer, frame counter, config registers.
// Depends on ket_pkg, ket_if, ket_mem and ket_cmp.
//
// Usage:
//   in_ch carries one item (cmd, keycode); out_ch returns exactly one result
//   per item. Both channels transfer when valid and ready are high at a clock
//   edge. Key registers are written through cfg_write/cfg_index/cfg_data while
//   the block is idle, a rule on the user that the block does not enforce.
//   Work per item, from input transfer until the result is offered on out_ch:
//     frame end, unknown command, out-of-range key: straight to the result
//     key down / key up: table read, then write back
//     key query: two stamp compares on the shared comparator
//     direction query: eight table reads and twelve passes through the
//     single comparator, one per cycle
//   The single-port key table and the one comparator set this sequence; the
//   block works on one item at a time.
//   After reset the key table is swept to zero, one entry per cycle, through
//   all KEY_COUNT entries; in_ch.ready stays low meanwhile and config writes are
//   still taken. The frame counter restarts at 1.
//   A result waits in the output register while the receiver stalls; the next
//   item may be taken meanwhile, and its result is held until the first goes.
module key_edge_tracker_with_direction_core #(
  parameter int KEY_COUNT  = 512,
  parameter int STAMP_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  ket_in_if.sink                  in_ch,
  ket_out_if.source               out_ch,
  input  logic                    cfg_write,
  input  logic [ket_pkg::REG_IW-1:0] cfg_index,
  input  logic [ket_pkg::CFG_W-1:0]  cfg_data
);
  import ket_pkg::*;

  localparam int IW   = $clog2(KEY_COUNT);
  localparam int MW   = 2 * STAMP_BITS + 1;
  localparam int CMPW = KEY_W + 1;
  localparam logic [CMPW-1:0] KEY_LIMIT = CMPW'(KEY_COUNT);
  localparam logic [IW-1:0]   LAST_KEY  = IW'(KEY_COUNT - 1);

  state_t state, state_next;

  logic [CFG_W-1:0]      cfg_regs [REG_CNT];
  logic [STAMP_BITS-1:0] frame;
  logic [STAMP_BITS-1:0] frame_prev;
  logic [IW-1:0]         clr_addr;
  logic [CMD_W-1:0]      cmd_q;
  logic [IW-1:0]         key_q;
  logic [STEP_W-1:0]     step;
  logic                  dir_held;
  logic [STAMP_BITS-1:0] dir_max;
  logic [STAMP_BITS-1:0] best;
  logic [DIR_W-1:0]      best_code;
  logic                  res_held;
  logic                  res_pressed;
  logic                  res_released;
  logic                  res_range;

  logic                  out_valid;
  logic                  out_load;
  logic                  in_fire;
  logic                  in_range;
  logic                  is_key_cmd;

  logic                  mem_rd;
  logic                  mem_wr;
  logic [IW-1:0]         mem_addr;
  logic [MW-1:0]         mem_wdata;
  logic [MW-1:0]         mem_rdata;
  logic                  ent_held;
  logic [STAMP_BITS-1:0] ent_press;
  logic [STAMP_BITS-1:0] ent_release;
  logic                  tbl_rd;
  logic [IW-1:0]         tbl_addr;

  logic [CFG_W-1:0]      scan_key;
  logic                  scan_in_range;
  logic                  scan_held;
  logic [STAMP_BITS-1:0] scan_stamp;

  logic [STAMP_BITS-1:0] cmp_a;
  logic [STAMP_BITS-1:0] cmp_b;
  logic                  cmp_gt;
  logic                  cmp_eq;

  ket_mem #(
    .DEPTH (KEY_COUNT),
    .WIDTH (MW),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .rd_en (tbl_rd),
    .wr_en (mem_wr),
    .addr  (tbl_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ket_cmp #(
    .W (STAMP_BITS)
  ) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (cmp_gt),
    .eq (cmp_eq)
  );

  assign ent_held    = mem_rdata[MW-1];
  assign ent_press   = mem_rdata[MW-2:STAMP_BITS];
  assign ent_release = mem_rdata[STAMP_BITS-1:0];
  assign frame_prev  = frame - STAMP_BITS'(1);

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = {1'b0, in_ch.keycode} < KEY_LIMIT;
  assign is_key_cmd  = (in_ch.cmd == CMD_KEY_DOWN) || (in_ch.cmd == CMD_KEY_UP) ||
                       (in_ch.cmd == CMD_KEY_QUERY);
  assign out_load    = (state == ST_DONE) && (!out_valid || out_ch.ready);

  // Direction scan: key under inspection and what the table says about it.
  assign scan_key      = cfg_regs[dir_reg_index(step)];
  assign scan_in_range = CMPW'(scan_key) < KEY_LIMIT;
  assign scan_held     = scan_in_range && ent_held;
  assign scan_stamp    = scan_in_range ? ent_press : '0;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_KEY) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (is_key_cmd && in_range) begin
            state_next = ST_KEY_EXEC;
          end else if (in_ch.cmd == CMD_DIR_QUERY) begin
            state_next = ST_DIR_ISSUE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_KEY_EXEC: begin
        state_next = (cmd_q == CMD_KEY_QUERY) ? ST_QRY_REL : ST_DONE;
      end
      ST_QRY_REL:   state_next = ST_DONE;
      ST_DIR_ISSUE: state_next = ST_DIR_ACC;
      ST_DIR_ACC: begin
        if (step[0]) begin
          state_next = ST_DIR_CMP;
        end
      end
      ST_DIR_CMP: begin
        state_next = (step == '1) ? ST_DONE : ST_DIR_ACC;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Table port and comparator operands
  always_comb begin
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    mem_addr  = key_q;
    mem_wdata = mem_rdata;
    cmp_a     = scan_stamp;
    cmp_b     = dir_max;
    case (state)
      ST_CLEAR: begin
        mem_wr    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_rd   = in_fire;
        mem_addr = in_ch.keycode[IW-1:0];
      end
      ST_KEY_EXEC: begin
        cmp_a = ent_press;
        cmp_b = frame_prev;
        if (cmd_q == CMD_KEY_DOWN) begin
          mem_wr    = 1'b1;
          mem_wdata = {1'b1, (ent_held ? ent_press : frame), ent_release};
        end else if (cmd_q == CMD_KEY_UP) begin
          mem_wr    = 1'b1;
          mem_wdata = {1'b0, ent_press, (ent_held ? frame : ent_release)};
        end
      end
      ST_QRY_REL: begin
        cmp_a = ent_release;
        cmp_b = frame_prev;
      end
      ST_DIR_ISSUE: begin
        mem_rd   = 1'b1;
        mem_addr = IW'(scan_key);
      end
      ST_DIR_ACC: begin
        cmp_a = scan_stamp;
        cmp_b = step[0] ? dir_max : '0;
      end
      ST_DIR_CMP: begin
        cmp_a = dir_max;
        cmp_b = best;
      end
      default: begin
      end
    endcase
  end

  // Prefetch the next scan entry while the current one is folded in
  logic [STEP_W-1:0] step_inc;
  logic [CFG_W-1:0]  next_scan_key;
  assign step_inc      = step + STEP_W'(1);
  assign next_scan_key = cfg_regs[dir_reg_index(step_inc)];

  logic              pre_rd;
  logic [IW-1:0]     pre_addr;
  assign pre_rd   = ((state == ST_DIR_ACC) && !step[0]) ||
                    ((state == ST_DIR_CMP) && (step != '1));
  assign pre_addr = IW'(next_scan_key);

  assign tbl_rd   = mem_rd || pre_rd;
  assign tbl_addr = pre_rd ? pre_addr : mem_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_CNT; i++) begin
        cfg_regs[i] <= REG_RESET[i];
      end
    end else if (cfg_write) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= STAMP_BITS'(1);
    end else if (in_fire && (in_ch.cmd == CMD_FRAME_END)) begin
      frame <= frame + STAMP_BITS'(1);
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q        <= in_ch.cmd;
      key_q        <= in_ch.keycode[IW-1:0];
      step         <= '0;
      dir_held     <= 1'b0;
      dir_max      <= '0;
      best         <= '0;
      best_code    <= '0;
      res_held     <= 1'b0;
      res_pressed  <= 1'b0;
      res_released <= 1'b0;
      res_range    <= is_key_cmd && !in_range;
    end else begin
      case (state)
        ST_KEY_EXEC: begin
          if (cmd_q == CMD_KEY_QUERY) begin
            res_held    <= ent_held;
            res_pressed <= cmp_eq;
          end
        end
        ST_QRY_REL: res_released <= cmp_eq;
        ST_DIR_ACC: begin
          dir_held <= step[0] ? (dir_held || scan_held) : scan_held;
          if (!step[0] || cmp_gt) begin
            dir_max <= scan_stamp;
          end
          if (!step[0]) begin
            step <= step_inc;
          end
        end
        ST_DIR_CMP: begin
          // strict compare keeps the earlier direction on a tie
          if (dir_held && cmp_gt) begin
            best      <= dir_max;
            best_code <= dir_code_of(step);
          end
          step <= step_inc;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.key_is_held      <= res_held;
      out_ch.key_was_pressed  <= res_pressed;
      out_ch.key_was_released <= res_released;
      out_ch.direction_valid  <= best != '0;
      out_ch.direction_code   <= best_code;
      out_ch.range_error      <= res_range;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

[test/key_edge_tracker_with_direction_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the key edge tracker: directed table, then random traffic.
// Depends on ket_pkg, ket_if and the key_edge_tracker_with_direction_core RTL.
module key_edge_tracker_with_direction_core_tb;
  import ket_pkg::*;

  localparam int KEYS         = 512;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_AT      = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 430;

  // Commands the block does not decode; they must come back all zero.
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  // Key registers of each direction, indexed by direction code.
  localparam logic [REG_IW-1:0] DIR_PRI_REG [4] = '{REG_UP_PRI, REG_LEFT_PRI,
                                                    REG_DOWN_PRI, REG_RIGHT_PRI};
  localparam logic [REG_IW-1:0] DIR_ALT_REG [4] = '{REG_UP_ALT, REG_LEFT_ALT,
                                                    REG_DOWN_ALT, REG_RIGHT_ALT};

  typedef struct packed {
    logic             key_is_held;
    logic             key_was_pressed;
    logic             key_was_released;
    logic             direction_valid;
    logic [DIR_W-1:0] direction_code;
    logic             range_error;
  } key_result_t;

  typedef struct packed {
    logic        fixed;
    key_result_t res;
  } item_note_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic             fixed;
    key_result_t      res;
  } probe_row_t;

  typedef enum logic [1:0] {DRAIN_FREE, DRAIN_COIN, DRAIN_SLOW, DRAIN_MASK} drain_mode_t;

  localparam key_result_t RES_NONE      = '0;
  localparam key_result_t RES_RANGE_ERR = '{range_error: 1'b1, default: '0};
  // Never-touched key in frame 1: both stamps equal frame 0.
  localparam key_result_t RES_UNTOUCHED = '{key_was_pressed: 1'b1, key_was_released: 1'b1,
                                            default: '0};

  localparam int PROBE_COUNT = 26;
  localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
    '{CMD_KEY_QUERY,  10'd5,    1'b1, RES_UNTOUCHED},
    '{CMD_KEY_QUERY,  10'd511,  1'b1, RES_UNTOUCHED},
    '{CMD_KEY_QUERY,  10'd0,    1'b1, RES_UNTOUCHED},
    '{CMD_KEY_QUERY,  10'd512,  1'b1, RES_RANGE_ERR},
    '{CMD_KEY_DOWN,   10'd1023, 1'b1, RES_RANGE_ERR},
    '{CMD_KEY_UP,     10'd700,  1'b1, RES_RANGE_ERR},
    '{CMD_RSVD_FIRST, 10'd0,    1'b1, RES_NONE},
    '{CMD_RSVD_MID,   10'd1023, 1'b1, RES_NONE},
    '{CMD_RSVD_LAST,  10'd341,  1'b1, RES_NONE},
    '{CMD_DIR_QUERY,  10'd0,    1'b1, RES_NONE},
    '{CMD_KEY_DOWN,   10'd273,  1'b1, RES_NONE},   // up arrow
    '{CMD_DIR_QUERY,  10'd0,    1'b0, RES_NONE},
    '{CMD_FRAME_END,  10'd0,    1'b1, RES_NONE},
    '{CMD_KEY_QUERY,  10'd273,  1'b0, RES_NONE},
    '{CMD_KEY_DOWN,   10'd100,  1'b1, RES_NONE},   // right alternate
    '{CMD_KEY_DOWN,   10'd97,   1'b1, RES_NONE},   // left alternate, same frame
    '{CMD_DIR_QUERY,  10'd0,    1'b0, RES_NONE},   // tie goes to right
    '{CMD_KEY_DOWN,   10'd273,  1'b1, RES_NONE},   // already held, stamp stays
    '{CMD_KEY_UP,     10'd100,  1'b1, RES_NONE},
    '{CMD_DIR_QUERY,  10'd0,    1'b0, RES_NONE},
    '{CMD_FRAME_END,  10'd0,    1'b1, RES_NONE},
    '{CMD_KEY_UP,     10'd100,  1'b1, RES_NONE},   // not held, no release stamp
    '{CMD_KEY_QUERY,  10'd100,  1'b0, RES_NONE},
    '{CMD_KEY_DOWN,   10'd511,  1'b1, RES_NONE},
    '{CMD_KEY_QUERY,  10'd511,  1'b0, RES_NONE},
    '{CMD_DIR_QUERY,  10'd0,    1'b0, RES_NONE}
  };

  logic clk;
  logic rst;
  logic              cfg_write;
  logic [REG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  ket_in_if  in_ch();
  ket_out_if out_ch();

  key_edge_tracker_with_direction_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Tracker model state.
  logic             down_map    [KEYS];
  logic [31:0]      press_stamp [KEYS];
  logic [31:0]      rel_stamp   [KEYS];
  logic [31:0]      frame_no;
  logic [CFG_W-1:0] key_reg     [REG_CNT];

  key_result_t expected[$];
  item_note_t  item_notes[$];

  bit hold_req;
  int mismatches;
  int items_in;
  int results_seen;
  int dir_hits;
  int range_hits;

  function automatic void reset_tracker();
    for (int i = 0; i < KEYS; i++) begin
      down_map[i]    = 1'b0;
      press_stamp[i] = '0;
      rel_stamp[i]   = '0;
    end
    for (int i = 0; i < REG_CNT; i++) key_reg[i] = REG_RESET[i];
    frame_no = 32'd1;
  endfunction

  function automatic key_result_t track_item(input logic [CMD_W-1:0] c,
                                             input logic [KEY_W-1:0] k);
    key_result_t      r;
    logic [31:0]      prev_frame;
    logic [31:0]      best;
    logic [31:0]      s_a;
    logic [31:0]      s_b;
    logic [31:0]      s_dir;
    logic [CFG_W-1:0] ka;
    logic [CFG_W-1:0] kb;
    logic             held_a;
    logic             held_b;
    logic [DIR_W-1:0] pick;
    r = RES_NONE;
    prev_frame = frame_no - 32'd1;
    best = '0;
    pick = DIR_UP;
    if ((c == CMD_KEY_DOWN || c == CMD_KEY_UP || c == CMD_KEY_QUERY) && k >= KEYS) begin
      r.range_error = 1'b1;
    end else begin
      case (c)
        CMD_KEY_DOWN: begin
          if (!down_map[k]) press_stamp[k] = frame_no;
          down_map[k] = 1'b1;
        end
        CMD_KEY_UP: begin
          if (down_map[k]) rel_stamp[k] = frame_no;
          down_map[k] = 1'b0;
        end
        CMD_FRAME_END: frame_no = frame_no + 32'd1;
        CMD_KEY_QUERY: begin
          r.key_is_held      = down_map[k];
          r.key_was_pressed  = (press_stamp[k] == prev_frame);
          r.key_was_released = (rel_stamp[k] == prev_frame);
        end
        CMD_DIR_QUERY: begin
          // Scan right, down, left, up; strict compare keeps the earlier on ties.
          for (int d = 3; d >= 0; d--) begin
            ka = key_reg[DIR_PRI_REG[d]];
            kb = key_reg[DIR_ALT_REG[d]];
            held_a = (ka < KEYS) && down_map[ka];
            held_b = (kb < KEYS) && down_map[kb];
            if (held_a || held_b) begin
              s_a = (ka < KEYS) ? press_stamp[ka] : '0;
              s_b = (kb < KEYS) ? press_stamp[kb] : '0;
              s_dir = (s_a > s_b) ? s_a : s_b;
              if (s_dir > best) begin
                best = s_dir;
                pick = DIR_W'(d);
              end
            end
          end
          if (best != '0) begin
            r.direction_valid = 1'b1;
            r.direction_code  = pick;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : tracker_check
    key_result_t want;
    item_note_t  note;
    if (rst) begin
      reset_tracker();
    end else begin
      if (cfg_write) key_reg[cfg_index] = cfg_data;
      if (out_ch.valid && out_ch.ready) begin
        if (expected.size() == 0) begin
          $error("result transfer with nothing outstanding");
          mismatches++;
        end else begin
          want = expected.pop_front();
          check_field("key_is_held", 4'(want.key_is_held), 4'(out_ch.key_is_held));
          check_field("key_was_pressed", 4'(want.key_was_pressed),
                      4'(out_ch.key_was_pressed));
          check_field("key_was_released", 4'(want.key_was_released),
                      4'(out_ch.key_was_released));
          check_field("direction_valid", 4'(want.direction_valid),
                      4'(out_ch.direction_valid));
          check_field("direction_code", 4'(want.direction_code),
                      4'(out_ch.direction_code));
          check_field("range_error", 4'(want.range_error), 4'(out_ch.range_error));
          results_seen++;
          if (want.direction_valid) dir_hits++;
          if (want.range_error) range_hits++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = track_item(in_ch.cmd, in_ch.keycode);
        note = item_notes.pop_front();
        expected.push_back(note.fixed ? note.res : want);
        items_in++;
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall patterns in segments, plus one long hold-off on request.
  initial begin : result_drain
    int          seg;
    drain_mode_t mode;
    logic [7:0]  mask;
    out_ch.ready = 1'b0;
    forever begin
      seg  = $urandom_range(20, 150);
      mode = drain_mode_t'($urandom_range(0, 3));
      mask = 8'($urandom);
      for (int tick = 0; tick < seg; tick++) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          DRAIN_FREE: out_ch.ready <= 1'b1;
          DRAIN_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
          DRAIN_SLOW: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    out_ch.ready <= mask[tick % 8];
        endcase
      end
    end
  end

  // Call at a rising edge; returns at the edge of the transfer.
  task automatic offer_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                            input logic fixed, input key_result_t res);
    item_note_t note;
    note.fixed = fixed;
    note.res   = res;
    item_notes.push_back(note);
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c;
    in_ch.keycode <= k;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_keys(input logic [CFG_W-1:0] vals [REG_CNT]);
    for (int i = 0; i < REG_CNT; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_IW'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic void pick_item(output logic [CMD_W-1:0] c, output logic [KEY_W-1:0] k);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30)      c = CMD_KEY_DOWN;
    else if (roll < 54) c = CMD_KEY_UP;
    else if (roll < 66) c = CMD_FRAME_END;
    else if (roll < 80) c = CMD_KEY_QUERY;
    else if (roll < 94) c = CMD_DIR_QUERY;
    else                c = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
    roll = $urandom_range(0, 99);
    // Mostly direction keys so the picker sees real contention.
    if (roll < 60)      k = {1'b0, key_reg[$urandom_range(0, REG_CNT - 1)]};
    else if (roll < 85) k = KEY_W'($urandom_range(0, 15));
    else                k = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
  endfunction

  task automatic run_random(input int count);
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    int               burst_left;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (n == HOLD_AT) begin
        // Keep offering while the result side holds off, to back up the block.
        hold_req   = 1'b1;
        burst_left = 16;
      end
      pick_item(c, k);
      offer_item(c, k, 1'b0, RES_NONE);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(10, 40);
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14));
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] keymap [REG_CNT];
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_FRAME_END;
    in_ch.keycode = '0;
    hold_req      = 1'b0;
    mismatches    = 0;
    items_in      = 0;
    results_seen  = 0;
    dir_hits      = 0;
    range_hits    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PROBE_COUNT; i++) begin
      offer_item(PROBE_ROWS[i].cmd, PROBE_ROWS[i].key, PROBE_ROWS[i].fixed,
                 PROBE_ROWS[i].res);
      pause_sender($urandom_range(0, 5));
    end
    drain_results();

    run_random(PHASE_ITEMS);
    drain_results();

    // Random key map with both extremes on the up keys.
    foreach (keymap[i]) keymap[i] = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    keymap[REG_UP_PRI] = '0;
    keymap[REG_UP_ALT] = '1;
    load_keys(keymap);
    run_random(PHASE_ITEMS);
    drain_results();

    // Shared keys: up/left share one key, down/right another, to force ties.
    keymap[REG_UP_PRI]    = 9'd5;
    keymap[REG_UP_ALT]    = 9'd511;
    keymap[REG_LEFT_PRI]  = 9'd5;
    keymap[REG_LEFT_ALT]  = 9'd6;
    keymap[REG_DOWN_PRI]  = 9'd7;
    keymap[REG_DOWN_ALT]  = 9'd0;
    keymap[REG_RIGHT_PRI] = 9'd7;
    keymap[REG_RIGHT_ALT] = 9'd8;
    load_keys(keymap);
    run_random(PHASE_ITEMS);
    drain_results();

    $display("Covered %0d items over three key maps and %0d frames;", items_in, frame_no - 1);
    $display("%0d results checked, %0d direction picks, %0d range errors.",
             results_seen, dir_hits, range_hits);
    if (mismatches == 0 && expected.size() == 0) begin
      $display("** key_edge_tracker_with_direction_core: PASSED **");
    end else begin
      $display("** key_edge_tracker_with_direction_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("** key_edge_tracker_with_direction_core: FAILED **");
    $finish;
  end

endmodule
